// File: rtl/core/htok_pkg.sv
// shared types and constants for the http header line tokenizer
// no dependencies

package htok_pkg;

    localparam int unsigned MAX_LEN_W = 18;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 18'd255000;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_NAME   = 4'd1,
        ST_COLON  = 4'd2,
        ST_SPACE  = 4'd3,
        ST_VALUE  = 4'd4,
        ST_CR     = 4'd5,
        ST_LF     = 4'd6,
        ST_END_CR = 4'd7,
        ST_DONE   = 4'd8,
        ST_ERROR  = 4'd9
    } parser_state_t;

    typedef enum logic [2:0] {
        TK_SEP   = 3'd0,
        TK_NAME  = 3'd1,
        TK_VALUE = 3'd2,
        TK_LINE  = 3'd3,
        TK_END   = 3'd4,
        TK_ERROR = 3'd5,
        TK_BODY  = 3'd6
    } token_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_request;
    } in_item_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [7:0]  byte_out;
    } result_t;

endpackage

// File: rtl/core/http_header_line_tokenizer_unit.sv
// HTTP header tokenizer: one token per accepted byte, one byte per cycle
// with no stalls downstream; a byte is registered in htok_in_reg, its
// token in htok_out_reg. The rate is set by the parser state register,
// updated on each accepted byte; max_len_reg is set via cfg_we / cfg_wdata.
// depends on htok_pkg, htok_in_reg, htok_parser, htok_out_reg

module http_header_line_tokenizer_unit
    import htok_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_new_request,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_token_kind,
    output logic [7:0]           m_byte_out
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     advance;
    result_t  result;
    result_t  m_result;

    assign s_item.data_byte   = s_data_byte;
    assign s_item.new_request = s_new_request;
    assign advance            = item_valid && can_load;
    assign m_token_kind       = m_result.token_kind;
    assign m_byte_out         = m_result.byte_out;

    htok_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    htok_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    htok_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule

// File: rtl/core/htok_in_reg.sv
// input register stage: holds one accepted byte until the parser takes it
// depends on htok_pkg

module htok_in_reg
    import htok_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: rtl/core/htok_parser.sv
// parser state, value offset and length limit, with the per-byte decode
// depends on htok_pkg

module htok_parser
    import htok_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata,
    input  logic                 advance,
    input  in_item_t             item,
    output result_t              result
);

    parser_state_t        state_reg;
    parser_state_t        state_next;
    parser_state_t        cur_state;
    logic [MAX_LEN_W-1:0] offset_reg;
    logic [MAX_LEN_W-1:0] offset_next;
    logic [MAX_LEN_W-1:0] cur_offset;
    logic [MAX_LEN_W-1:0] max_len_reg;
    logic [7:0]           b;
    logic                 room;

    assign b          = item.data_byte;
    assign cur_state  = item.new_request ? ST_START : state_reg;
    assign cur_offset = item.new_request ? '0 : offset_reg;
    assign room       = cur_offset < max_len_reg;

    // next state
    always_comb begin
        state_next = ST_ERROR;
        case (cur_state)
            ST_START: begin
                state_next = (b inside {CH_CR, CH_LF}) ? ST_START : ST_NAME;
            end
            ST_NAME: begin
                if (b == CH_COLON) begin
                    state_next = ST_COLON;
                end else if (!(b inside {CH_CR, CH_LF})) begin
                    state_next = ST_NAME;
                end
            end
            ST_COLON: begin
                if (b == CH_SPACE) begin
                    state_next = ST_SPACE;
                end
            end
            ST_SPACE: begin
                state_next = ST_VALUE;
            end
            ST_VALUE: begin
                if (b == CH_CR) begin
                    state_next = ST_CR;
                end else if (room) begin
                    state_next = ST_VALUE;
                end
            end
            ST_CR: begin
                if (b == CH_LF) begin
                    state_next = ST_LF;
                end
            end
            ST_LF: begin
                state_next = (b == CH_CR) ? ST_END_CR : ST_NAME;
            end
            ST_END_CR: begin
                if (b == CH_LF) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_DONE;
            end
            default: begin
                state_next = ST_ERROR;
            end
        endcase
    end

    // token kind and echoed byte
    always_comb begin
        result.token_kind = TK_ERROR;
        result.byte_out   = '0;
        case (cur_state)
            ST_START: begin
                if (b inside {CH_CR, CH_LF}) begin
                    result.token_kind = TK_SEP;
                end else begin
                    result.token_kind = TK_NAME;
                    result.byte_out   = b;
                end
            end
            ST_NAME: begin
                if (b == CH_COLON) begin
                    result.token_kind = TK_SEP;
                end else if (!(b inside {CH_CR, CH_LF})) begin
                    result.token_kind = TK_NAME;
                    result.byte_out   = b;
                end
            end
            ST_COLON: begin
                if (b == CH_SPACE) begin
                    result.token_kind = TK_SEP;
                end
            end
            ST_SPACE: begin
                result.token_kind = TK_VALUE;
                result.byte_out   = b;
            end
            ST_VALUE: begin
                if (b == CH_CR) begin
                    result.token_kind = TK_SEP;
                end else if (room) begin
                    result.token_kind = TK_VALUE;
                    result.byte_out   = b;
                end
            end
            ST_CR: begin
                if (b == CH_LF) begin
                    result.token_kind = TK_LINE;
                end
            end
            ST_LF: begin
                if (b == CH_CR) begin
                    result.token_kind = TK_SEP;
                end else begin
                    result.token_kind = TK_NAME;
                    result.byte_out   = b;
                end
            end
            ST_END_CR: begin
                if (b == CH_LF) begin
                    result.token_kind = TK_END;
                end
            end
            ST_DONE: begin
                result.token_kind = TK_BODY;
                result.byte_out   = b;
            end
            default: begin
                result.token_kind = TK_ERROR;
            end
        endcase
    end

    // value offset
    always_comb begin
        offset_next = cur_offset;
        if (cur_state == ST_SPACE) begin
            offset_next = '0;
        end else if (cur_state == ST_VALUE && b != CH_CR && room) begin
            offset_next = cur_offset + MAX_LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_START;
            offset_reg  <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            if (advance) begin
                state_reg  <= state_next;
                offset_reg <= offset_next;
            end
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

endmodule

// File: rtl/core/htok_out_reg.sv
// result register: holds one token until the downstream transfer
// depends on htok_pkg

module htok_out_reg
    import htok_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule
